// ----- hw/rtl/tsbd_pkg.sv -----
// tsbd_pkg: shared types, codes and helpers of the score bytestream decoder
// no dependencies; used by the event and register interfaces, the decoder core and the top level
package tsbd_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_GENERATORS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_PRESENT    = 4'd1;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_INSTR    = 4'hC;
  localparam logic [7:0] SKIP_CODE_A  = 8'hF0;
  localparam logic [7:0] SKIP_CODE_B  = 8'hE0;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_CMD    = 3'd0,
    PH_DLY_LO = 3'd1,
    PH_NOTE   = 3'd2,
    PH_VOL    = 3'd3,
    PH_INSTR  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_DELAY      = 3'd0,
    EV_NOTE_ON    = 3'd1,
    EV_NOTE_OFF   = 3'd2,
    EV_INSTR      = 3'd3,
    EV_OFF_SILENT = 3'd4,
    EV_HALT       = 3'd5
  } event_kind_t;

  typedef struct packed {
    logic [4:0] active_generators;
    logic       volume_present;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  generator;
    logic [7:0]  note;
    logic [7:0]  volume;
    logic [6:0]  instrument;
    logic [14:0] delay_ms;
    logic [31:0] time_ms;
    logic        warning;
    logic [15:0] unnecessary_stops;
    logic [15:0] merged_delays;
    logic [15:0] skipped_notes;
    logic [3:0]  highest_generator;
  } score_event_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == COUNT_MAX) ? c : c + 16'd1;
  endfunction

endpackage

// ----- hw/rtl/tsbd_byte_if.sv -----
// tsbd_byte_if: valid/ready channel carrying one score byte per word
// depends on nothing
interface tsbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;

  modport source(output valid, output byte_value, input ready);
  modport sink(input valid, input byte_value, output ready);
endinterface

// ----- hw/rtl/tsbd_event_if.sv -----
// tsbd_event_if: valid/ready channel carrying one decoded event per word
// depends on tsbd_pkg for the event type
interface tsbd_event_if;
  logic                  valid;
  logic                  ready;
  tsbd_pkg::score_event_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tsbd_cfg_if.sv -----
// tsbd_cfg_if: valid/ready register write channel, index and data per word
// depends on tsbd_pkg for the field widths
interface tsbd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tsbd_pkg::CFG_INDEX_W-1:0] index;
  logic [tsbd_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/tsbd_core.sv -----
// tsbd_core: parser state, per-generator tables, counters and event build
// depends on tsbd_pkg; state advances on step, event is combinational
module tsbd_core #(
  parameter int GENERATORS = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             byte_value,
  input  tsbd_pkg::cfg_t         cfg,
  output logic                   produce,
  output tsbd_pkg::score_event_t ev
);

  localparam int IDXW = (GENERATORS > 1) ? $clog2(GENERATORS) : 1;

  tsbd_pkg::phase_t phase, phase_next;
  logic                  halted, halted_next;
  logic [7:0]            pending, pending_next;
  logic [3:0]            pending_gen, pending_gen_next;
  logic                  since_delay, since_delay_next;
  logic                  warn_flag, warn_flag_next;
  logic [TIME_WIDTH-1:0] elapsed, elapsed_next;
  logic [15:0]           stop_cnt, stop_cnt_next;
  logic [15:0]           delay_cnt, delay_cnt_next;
  logic [15:0]           skip_cnt, skip_cnt_next;
  logic [3:0]            max_gen, max_gen_next;

  logic [GENERATORS-1:0] note_on;
  logic [GENERATORS-1:0] stopped;
  logic [7:0]            vol_tab [GENERATORS];
  logic [6:0]            ins_tab [GENERATORS];

  logic [3:0]      gen;
  logic [IDXW-1:0] idx;
  logic            gen_ok;
  logic [7:0]      rd_vol;
  logic [6:0]      rd_ins;
  logic            rd_on;
  logic            rd_stopped;
  logic [14:0]     delay;

  logic       vol_we, ins_we, on_set, on_clr, stop_set, stop_clr_all;
  logic [7:0] vol_wd;

  assign gen    = (phase == tsbd_pkg::PH_CMD) ? byte_value[3:0] : pending_gen;
  assign idx    = gen[IDXW-1:0];
  assign gen_ok = {1'b0, gen} < 5'(GENERATORS);
  assign rd_vol     = gen_ok ? vol_tab[idx] : 8'd0;
  assign rd_ins     = gen_ok ? ins_tab[idx] : 7'd0;
  assign rd_on      = gen_ok & note_on[idx];
  assign rd_stopped = gen_ok & stopped[idx];
  assign delay  = {pending[6:0], byte_value};

  always_comb begin
    phase_next       = phase;
    halted_next      = halted;
    pending_next     = pending;
    pending_gen_next = pending_gen;
    since_delay_next = since_delay;
    warn_flag_next   = warn_flag;
    elapsed_next     = elapsed;
    stop_cnt_next    = stop_cnt;
    delay_cnt_next   = delay_cnt;
    skip_cnt_next    = skip_cnt;
    max_gen_next     = max_gen;
    vol_we       = 1'b0;
    vol_wd       = byte_value;
    ins_we       = 1'b0;
    on_set       = 1'b0;
    on_clr       = 1'b0;
    stop_set     = 1'b0;
    stop_clr_all = 1'b0;
    produce      = 1'b0;
    ev           = '0;
    ev.generator = gen;

    if (!halted) begin
      unique case (phase)
        tsbd_pkg::PH_DLY_LO: begin
          if (!since_delay) begin
            delay_cnt_next = tsbd_pkg::sat_inc(delay_cnt);
          end
          since_delay_next = 1'b0;
          warn_flag_next   = 1'b0;
          elapsed_next     = elapsed + TIME_WIDTH'(delay);
          stop_clr_all     = 1'b1;
          phase_next       = tsbd_pkg::PH_CMD;
          produce          = 1'b1;
          ev.event_kind    = tsbd_pkg::EV_DELAY;
          ev.generator     = 4'd0;
          ev.delay_ms      = delay;
          ev.warning       = warn_flag | ~since_delay;
        end
        tsbd_pkg::PH_NOTE, tsbd_pkg::PH_VOL: begin
          if (phase == tsbd_pkg::PH_NOTE && cfg.volume_present) begin
            pending_next = byte_value;
            phase_next   = tsbd_pkg::PH_VOL;
          end else begin
            vol_we = gen_ok & (phase == tsbd_pkg::PH_VOL);
            on_set = gen_ok;
            if (rd_stopped) begin
              stop_cnt_next  = tsbd_pkg::sat_inc(stop_cnt);
              warn_flag_next = 1'b1;
            end
            if ({1'b0, gen} >= cfg.active_generators) begin
              skip_cnt_next = tsbd_pkg::sat_inc(skip_cnt);
            end
            phase_next    = tsbd_pkg::PH_CMD;
            produce       = 1'b1;
            ev.event_kind = tsbd_pkg::EV_NOTE_ON;
            ev.note       = (phase == tsbd_pkg::PH_VOL) ? pending : byte_value;
            ev.volume     = vol_we ? byte_value : rd_vol;
            ev.instrument = rd_ins;
          end
        end
        tsbd_pkg::PH_INSTR: begin
          ins_we        = gen_ok;
          phase_next    = tsbd_pkg::PH_CMD;
          produce       = 1'b1;
          ev.event_kind = tsbd_pkg::EV_INSTR;
          ev.volume     = rd_vol;
          ev.instrument = gen_ok ? byte_value[6:0] : 7'd0;
        end
        default: begin
          phase_next = tsbd_pkg::PH_CMD;
          if (!byte_value[7]) begin
            pending_next = byte_value;
            phase_next   = tsbd_pkg::PH_DLY_LO;
          end else if (byte_value != tsbd_pkg::SKIP_CODE_A &&
                       byte_value != tsbd_pkg::SKIP_CODE_B) begin
            since_delay_next = 1'b1;
            pending_gen_next = gen;
            if (gen > max_gen) begin
              max_gen_next = gen;
            end
            unique case (byte_value[7:4])
              tsbd_pkg::CMD_NOTE_ON: begin
                phase_next = tsbd_pkg::PH_NOTE;
              end
              tsbd_pkg::CMD_INSTR: begin
                phase_next = tsbd_pkg::PH_INSTR;
              end
              tsbd_pkg::CMD_NOTE_OFF: begin
                on_clr        = gen_ok;
                stop_set      = gen_ok;
                produce       = 1'b1;
                ev.event_kind = rd_on ? tsbd_pkg::EV_NOTE_OFF : tsbd_pkg::EV_OFF_SILENT;
                ev.volume     = rd_vol;
                ev.instrument = rd_ins;
              end
              default: begin
                halted_next   = 1'b1;
                produce       = 1'b1;
                ev.event_kind = tsbd_pkg::EV_HALT;
                ev.volume     = rd_vol;
                ev.instrument = rd_ins;
              end
            endcase
          end
        end
      endcase
    end

    ev.time_ms           = 32'(elapsed);
    ev.unnecessary_stops = stop_cnt_next;
    ev.merged_delays     = delay_cnt_next;
    ev.skipped_notes     = skip_cnt_next;
    ev.highest_generator = max_gen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tsbd_pkg::PH_CMD;
      halted      <= 1'b0;
      pending     <= 8'd0;
      pending_gen <= 4'd0;
      since_delay <= 1'b1;
      warn_flag   <= 1'b0;
      elapsed     <= '0;
      stop_cnt    <= 16'd0;
      delay_cnt   <= 16'd0;
      skip_cnt    <= 16'd0;
      max_gen     <= 4'd0;
      note_on     <= '0;
      stopped     <= '0;
      for (int i = 0; i < GENERATORS; i++) begin
        vol_tab[i] <= 8'd0;
        ins_tab[i] <= 7'd0;
      end
    end else if (step) begin
      phase       <= phase_next;
      halted      <= halted_next;
      pending     <= pending_next;
      pending_gen <= pending_gen_next;
      since_delay <= since_delay_next;
      warn_flag   <= warn_flag_next;
      elapsed     <= elapsed_next;
      stop_cnt    <= stop_cnt_next;
      delay_cnt   <= delay_cnt_next;
      skip_cnt    <= skip_cnt_next;
      max_gen     <= max_gen_next;
      if (vol_we) begin
        vol_tab[idx] <= vol_wd;
      end
      if (ins_we) begin
        ins_tab[idx] <= byte_value[6:0];
      end
      if (on_set) begin
        note_on[idx] <= 1'b1;
      end
      if (on_clr) begin
        note_on[idx] <= 1'b0;
      end
      if (stop_clr_all) begin
        stopped <= '0;
      end else if (stop_set) begin
        stopped[idx] <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tone_score_bytestream_decoder_top.sv -----
// tone_score_bytestream_decoder_top: byte input register, decoder core, event register
// depends on tsbd_pkg, the three channel interfaces and tsbd_core
//
// Accepts one score byte per clock unless the byte input stalls, and returns at most one
// event per byte. The byte passes the input register and its event the event register,
// where it is offered until the sink takes it; the parser state, tables and counters in
// tsbd_core update in the cycle the byte leaves the input register. The byte input stalls
// only while the event register holds an event that the sink has not taken and the byte in
// the input register would produce another. Register writes are taken in any cycle and
// must only be issued while no decoding is under way.
module tone_score_bytestream_decoder_top #(
  parameter int GENERATORS = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  tsbd_byte_if.sink   score,
  tsbd_event_if.source events,
  tsbd_cfg_if.sink    cfg
);

  tsbd_pkg::cfg_t         cfg_regs;
  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   s1_go;
  logic                   out_free;
  logic                   produce;
  tsbd_pkg::score_event_t core_ev;
  logic                   ev_valid;
  tsbd_pkg::score_event_t ev;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.active_generators <= 5'd6;
      cfg_regs.volume_present    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tsbd_pkg::CFG_ACTIVE_GENERATORS: cfg_regs.active_generators <= cfg.data[4:0];
        tsbd_pkg::CFG_VOLUME_PRESENT:    cfg_regs.volume_present    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign out_free    = ~ev_valid | events.ready;
  assign s1_go       = s1_valid & (~produce | out_free);
  assign score.ready = ~s1_valid | s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (score.valid && score.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (score.valid && score.ready) begin
      s1_byte <= score.byte_value;
    end
  end

  tsbd_core #(
    .GENERATORS(GENERATORS),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .byte_value(s1_byte),
    .cfg       (cfg_regs),
    .produce   (produce),
    .ev        (core_ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (s1_go && produce) begin
      ev_valid <= 1'b1;
    end else if (events.ready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && produce) begin
      ev <= core_ev;
    end
  end

  assign events.valid   = ev_valid;
  assign events.payload = ev;

`ifndef ASSERT_OFF
  a_no_lost_event: assert property (@(posedge clk) disable iff (rst)
    $fell(ev_valid) |-> $past(events.ready))
    else $error("event register dropped an untaken event");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !score.ready) |-> (produce && ev_valid && !events.ready))
    else $error("byte input stalled without a full event register");

  a_delay_fields: assert property (@(posedge clk) disable iff (rst)
    (ev_valid && ev.event_kind == tsbd_pkg::EV_DELAY) |->
      (ev.generator == 4'd0 && ev.volume == 8'd0 && ev.note == 8'd0))
    else $error("delay event carries generator data");
`endif

endmodule
